### hdl/pressure_temp_compensation_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Constants shared by the pressure and temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

	// Configuration register indexes.
	localparam int          CFG_IDX_W       = 8;
	localparam logic [7:0]  REG_TEMP_CALIB  = 8'd0;
	localparam logic [7:0]  REG_PRESS_A     = 8'd1;
	localparam logic [7:0]  REG_PRESS_B     = 8'd2;
	localparam logic [7:0]  REG_PRESS_C     = 8'd3;

	// Stream widths.
	localparam int          RAW_W           = 20;
	localparam int          IN_DATA_W       = 40;
	localparam int          OUT_DATA_W      = 48;

	// Formula constants.
	localparam logic [20:0] PRESS_FULL      = 21'd1048576;
	localparam logic [33:0] FINE_OFFSET     = 34'd128000;
	localparam logic [11:0] PRESS_SCALE     = 12'd3125;
	localparam logic [31:0] ROUND_HALF      = 32'd128;

	// Pipeline depth: twelve front stages, divider entry, 64 divide steps,
	// seven back stages.
	localparam int          DIV_STEPS       = 64;
	localparam int          PIPE_DEPTH      = 84;

endpackage

### hdl/pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// Each input beat carries one raw temperature and one raw pressure reading and
// gives exactly one output beat: temperature in 0.01 degC and pressure in Pa as
// Q24.8 with an invalid flag. A new beat is taken every cycle unless the skid
// register is full, which stalls the pipeline. The pressure path holds a 64-step
// restoring divider, with twelve stages ahead of it, seven after it, plus the
// output register. A skid register behind the output lets the pipeline run while
// a result waits. Calibration must be written through the cfg port only while no
// beat is in flight (not enforced by the block); the cfg port is always ready.
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_top_defines.svh"

module pressure_temp_compensation_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                        cfg_data,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ptc_pkg::IN_DATA_W-1:0]      s_tdata,   // raw_temp[19:0], raw_press[39:20]
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ptc_pkg::OUT_DATA_W-1:0]     m_tdata,   // temp_centi[15:0], press_q24_8[47:16]
	output logic                               m_tuser    // press_invalid[0]
);

	// Calibration registers.
	logic [47:0] temp_calib_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptc_pkg::REG_TEMP_CALIB: temp_calib_q <= cfg_data[47:0];
				ptc_pkg::REG_PRESS_A:    press_a_q    <= cfg_data;
				ptc_pkg::REG_PRESS_B:    press_b_q    <= cfg_data;
				ptc_pkg::REG_PRESS_C:    press_c_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Calibration fields.
	logic        [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = temp_calib_q[15:0];
	assign t2 = $signed(temp_calib_q[31:16]);
	assign t3 = $signed(temp_calib_q[47:32]);
	assign p1 = press_a_q[15:0];
	assign p2 = $signed(press_a_q[31:16]);
	assign p3 = $signed(press_a_q[47:32]);
	assign p4 = $signed(press_a_q[63:48]);
	assign p5 = $signed(press_b_q[15:0]);
	assign p6 = $signed(press_b_q[31:16]);
	assign p7 = $signed(press_b_q[47:32]);
	assign p8 = $signed(press_b_q[63:48]);
	assign p9 = $signed(press_c_q);

	// Flow control: the whole pipeline advances unless the skid register is full.
	logic                         en;
	logic [ptc_pkg::PIPE_DEPTH-1:0] vld_q;
	logic                         out_v_q, skid_v_q;
	logic [47:0]                  out_data_q, skid_data_q;
	logic                         out_user_q, skid_user_q;
	logic                         push, pop;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// Pipeline registers.
	logic [19:0]        raw_t, raw_p;
	logic signed [17:0] xa_s1;
	logic signed [16:0] d_s1;
	logic [20:0]        p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9;
	logic signed [31:0] a_s2, a_s3;
	logic [31:0]        dd_s2, b0_s3;
	logic signed [31:0] fine_s4;
	logic [15:0]        temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10,
	                    temp_s11, temp_s12;
	logic signed [33:0] v_s5;
	logic [63:0]        vv_s6;
	logic signed [49:0] vp5_s6, vp2_s6, vp5_s7, vp2_s7, vp5_s8, vp2_s8;
	logic signed [48:0] pp6l_s7, pp3l_s7;
	logic [31:0]        pp6h_s7, pp3h_s7;
	logic [63:0]        vvp6_s8, vvp3_s8;
	logic [63:0]        v2_s9, x_s9;
	logic [47:0]        xpl_s10;
	logic [31:0]        xph_s10;
	logic [63:0]        num0_s10;
	logic [63:0]        den_s11, den_s12;
	logic [43:0]        nl_s11;
	logic [31:0]        nh_s11;
	logic [63:0]        num_s12;

	// Divider stages: index 0 is the entry stage, index 64 holds the quotient.
	logic [63:0] dv_rem_s  [0:ptc_pkg::DIV_STEPS];
	logic [63:0] dv_nq_s   [0:ptc_pkg::DIV_STEPS];
	logic [63:0] dv_md_s   [0:ptc_pkg::DIV_STEPS];
	logic [15:0] dv_temp_s [0:ptc_pkg::DIV_STEPS];
	logic        dv_inv_s  [0:ptc_pkg::DIV_STEPS];
	logic        dv_neg_s  [0:ptc_pkg::DIV_STEPS];
	logic [63:0] rem_nx    [0:ptc_pkg::DIV_STEPS-1];
	logic [63:0] nq_nx     [0:ptc_pkg::DIV_STEPS-1];

	logic [63:0]        q_s78, q_s79, q_s80, q_s81, q_s82;
	logic [15:0]        temp_s78, temp_s79, temp_s80, temp_s81, temp_s82, temp_s83,
	                    temp_s84;
	logic               inv_s78, inv_s79, inv_s80, inv_s81, inv_s82, inv_s83, inv_s84;
	logic [63:0]        ll_s79;
	logic [31:0]        lh_s79, ph8_s79, p9h_s81;
	logic signed [48:0] pl8_s79, p9l_s81;
	logic [63:0]        phph_s80, p8q_s80, p8q_s81, p8q_s82;
	logic [63:0]        p9pp_s82;
	logic [63:0]        sum_s83;
	logic [31:0]        press_s84;

	// Front-stage arithmetic.
	logic signed [33:0] mul_a, mul_d;
	logic signed [31:0] dd_sh;
	logic signed [47:0] mul_b;
	logic [31:0]        t5;
	logic signed [31:0] ts;
	logic [15:0]        temp_w;
	logic signed [33:0] fine_x;
	logic signed [67:0] mul_vv;
	logic signed [49:0] mul_vp5, mul_vp2;
	logic signed [48:0] mul_6l, mul_6h, mul_3l, mul_3h;
	logic signed [63:0] pp6l_x, pp3l_x, vp5_x, vp2_x, p4_x, vvp3_sh;
	logic [47:0]        mul_xh;
	logic [43:0]        mul_nh;
	logic [63:0]        xsum;
	logic signed [63:0] num_sg, den_sg;

	always_comb begin
		mul_a   = xa_s1 * t2;
		mul_d   = d_s1 * d_s1;
		dd_sh   = $signed(dd_s2) >>> 12;
		mul_b   = dd_sh * t3;
		// Temperature in hundredths, clamped to 16 bits signed.
		t5      = fine_s4 * 32'd5 + ptc_pkg::ROUND_HALF;
		ts      = $signed(t5) >>> 8;
		if (ts < -32'sd32768)
			temp_w = 16'h8000;
		else if (ts > 32'sd32767)
			temp_w = 16'h7FFF;
		else
			temp_w = ts[15:0];
		fine_x  = fine_s4;
		mul_vv  = v_s5 * v_s5;
		mul_vp5 = v_s5 * p5;
		mul_vp2 = v_s5 * p2;
		mul_6l  = $signed({1'b0, vv_s6[31:0]}) * p6;
		mul_6h  = $signed({1'b0, vv_s6[63:32]}) * p6;
		mul_3l  = $signed({1'b0, vv_s6[31:0]}) * p3;
		mul_3h  = $signed({1'b0, vv_s6[63:32]}) * p3;
		pp6l_x  = pp6l_s7;
		pp3l_x  = pp3l_s7;
		vp5_x   = vp5_s8;
		vp2_x   = vp2_s8;
		p4_x    = p4;
		vvp3_sh = $signed(vvp3_s8) >>> 8;
		mul_xh  = x_s9[63:32] * p1;
		mul_nh  = num0_s10[63:32] * ptc_pkg::PRESS_SCALE;
		xsum    = {16'b0, xpl_s10} + {xph_s10, 32'b0};
		num_sg  = $signed(num_s12);
		den_sg  = $signed(den_s12);
	end

	// One restoring divide step per stage.
	always_comb begin
		for (int k = 0; k < ptc_pkg::DIV_STEPS; k++) begin
			logic [64:0] trial;
			logic [65:0] diff;
			trial = {dv_rem_s[k], dv_nq_s[k][63]};
			diff  = {1'b0, trial} - {2'b00, dv_md_s[k]};
			if (!diff[65])
				rem_nx[k] = diff[63:0];
			else
				rem_nx[k] = trial[63:0];
			nq_nx[k] = {dv_nq_s[k][62:0], !diff[65]};
		end
	end

	// Back-stage arithmetic.
	logic [63:0]        ph_w;
	logic [63:0]        mul_lh;
	logic signed [48:0] mul_8l, mul_8h, mul_9l, mul_9h;
	logic signed [63:0] pl8_x, p9l_x, w1, w2, s_sh, p7_x, res;
	logic [31:0]        press_w;

	always_comb begin
		ph_w    = $signed(q_s78) >>> 13;
		mul_lh  = ph_w[31:0] * ph_w[63:32];
		mul_8l  = $signed({1'b0, q_s78[31:0]}) * p8;
		mul_8h  = $signed({1'b0, q_s78[63:32]}) * p8;
		pl8_x   = pl8_s79;
		mul_9l  = $signed({1'b0, phph_s80[31:0]}) * p9;
		mul_9h  = $signed({1'b0, phph_s80[63:32]}) * p9;
		p9l_x   = p9l_s81;
		w1      = $signed(p9pp_s82) >>> 25;
		w2      = $signed(p8q_s82) >>> 19;
		s_sh    = $signed(sum_s83) >>> 8;
		p7_x    = p7;
		res     = s_sh + (p7_x <<< 4);
		// Pressure clamp to 32 bits unsigned.
		if (res[63])
			press_w = '0;
		else if (res[63:32] != 32'd0)
			press_w = 32'hFFFF_FFFF;
		else
			press_w = res[31:0];
	end

	assign raw_t = s_tdata[ptc_pkg::RAW_W-1:0];
	assign raw_p = s_tdata[2*ptc_pkg::RAW_W-1:ptc_pkg::RAW_W];

	// Payload registers, all moved by the common enable.
	always_ff @(posedge clk) begin
		if (en) begin
			// Temperature differences and pressure offset.
			xa_s1   <= $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
			d_s1    <= $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
			p_s1    <= ptc_pkg::PRESS_FULL - {1'b0, raw_p};
			// First temperature products.
			a_s2    <= $signed(mul_a[31:0]) >>> 11;
			dd_s2   <= mul_d[31:0];
			p_s2    <= p_s1;
			a_s3    <= a_s2;
			b0_s3   <= mul_b[31:0];
			p_s3    <= p_s2;
			// Fine temperature.
			fine_s4 <= a_s3 + ($signed(b0_s3) >>> 14);
			p_s4    <= p_s3;
			temp_s5 <= temp_w;
			v_s5    <= fine_x - $signed(ptc_pkg::FINE_OFFSET);
			p_s5    <= p_s4;
			// Pressure offset terms.
			vv_s6   <= mul_vv[63:0];
			vp5_s6  <= mul_vp5;
			vp2_s6  <= mul_vp2;
			temp_s6 <= temp_s5;
			p_s6    <= p_s5;
			pp6l_s7 <= mul_6l;
			pp6h_s7 <= mul_6h[31:0];
			pp3l_s7 <= mul_3l;
			pp3h_s7 <= mul_3h[31:0];
			vp5_s7  <= vp5_s6;
			vp2_s7  <= vp2_s6;
			temp_s7 <= temp_s6;
			p_s7    <= p_s6;
			vvp6_s8 <= pp6l_x + {pp6h_s7, 32'b0};
			vvp3_s8 <= pp3l_x + {pp3h_s7, 32'b0};
			vp5_s8  <= vp5_s7;
			vp2_s8  <= vp2_s7;
			temp_s8 <= temp_s7;
			p_s8    <= p_s7;
			v2_s9   <= vvp6_s8 + (vp5_x <<< 17) + (p4_x <<< 35);
			x_s9    <= 64'h0000_8000_0000_0000 + vvp3_sh + (vp2_x <<< 12);
			temp_s9 <= temp_s8;
			p_s9    <= p_s8;
			// Divisor and dividend.
			xpl_s10  <= x_s9[31:0] * p1;
			xph_s10  <= mul_xh[31:0];
			num0_s10 <= {12'b0, p_s9, 31'b0} - v2_s9;
			temp_s10 <= temp_s9;
			den_s11  <= $signed(xsum) >>> 33;
			nl_s11   <= num0_s10[31:0] * ptc_pkg::PRESS_SCALE;
			nh_s11   <= mul_nh[31:0];
			temp_s11 <= temp_s10;
			num_s12  <= {20'b0, nl_s11} + {nh_s11, 32'b0};
			den_s12  <= den_s11;
			temp_s12 <= temp_s11;
			// Divider entry: magnitudes, quotient sign and zero check.
			dv_rem_s[0]  <= '0;
			dv_nq_s[0]   <= num_s12[63] ? 64'(-num_sg) : num_s12;
			dv_md_s[0]   <= den_s12[63] ? 64'(-den_sg) : den_s12;
			dv_neg_s[0]  <= num_s12[63] ^ den_s12[63];
			dv_inv_s[0]  <= (den_s12 == 64'd0);
			dv_temp_s[0] <= temp_s12;
			for (int k = 0; k < ptc_pkg::DIV_STEPS; k++) begin
				dv_rem_s[k+1]  <= rem_nx[k];
				dv_nq_s[k+1]   <= nq_nx[k];
				dv_md_s[k+1]   <= dv_md_s[k];
				dv_neg_s[k+1]  <= dv_neg_s[k];
				dv_inv_s[k+1]  <= dv_inv_s[k];
				dv_temp_s[k+1] <= dv_temp_s[k];
			end
			// Signed quotient.
			q_s78    <= dv_neg_s[ptc_pkg::DIV_STEPS] ? (64'd0 - dv_nq_s[ptc_pkg::DIV_STEPS])
			                                         : dv_nq_s[ptc_pkg::DIV_STEPS];
			inv_s78  <= dv_inv_s[ptc_pkg::DIV_STEPS];
			temp_s78 <= dv_temp_s[ptc_pkg::DIV_STEPS];
			// Correction products.
			ll_s79   <= ph_w[31:0] * ph_w[31:0];
			lh_s79   <= mul_lh[31:0];
			pl8_s79  <= mul_8l;
			ph8_s79  <= mul_8h[31:0];
			q_s79    <= q_s78;
			inv_s79  <= inv_s78;
			temp_s79 <= temp_s78;
			phph_s80 <= ll_s79 + {lh_s79[30:0], 33'b0};
			p8q_s80  <= pl8_x + {ph8_s79, 32'b0};
			q_s80    <= q_s79;
			inv_s80  <= inv_s79;
			temp_s80 <= temp_s79;
			p9l_s81  <= mul_9l;
			p9h_s81  <= mul_9h[31:0];
			p8q_s81  <= p8q_s80;
			q_s81    <= q_s80;
			inv_s81  <= inv_s80;
			temp_s81 <= temp_s80;
			p9pp_s82 <= p9l_x + {p9h_s81, 32'b0};
			p8q_s82  <= p8q_s81;
			q_s82    <= q_s81;
			inv_s82  <= inv_s81;
			temp_s82 <= temp_s81;
			sum_s83  <= q_s82 + w1 + w2;
			inv_s83  <= inv_s82;
			temp_s83 <= temp_s82;
			press_s84 <= inv_s83 ? 32'd0 : press_w;
			inv_s84  <= inv_s83;
			temp_s84 <= temp_s83;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[ptc_pkg::PIPE_DEPTH-2:0], s_tvalid};
	end

	// Output register with skid stage.
	assign push = en && vld_q[ptc_pkg::PIPE_DEPTH-1];
	assign pop  = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_v_q || pop)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (push) begin
			if (!out_v_q || pop) begin
				out_data_q <= {press_s84, temp_s84};
				out_user_q <= inv_s84;
			end else begin
				skid_data_q <= {press_s84, temp_s84};
				skid_user_q <= inv_s84;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Checks.
	`PTC_ASSERT_NOW(a_skid_needs_out, skid_v_q, out_v_q, "skid holds a beat while output is empty")
	`PTC_ASSERT_NOW(a_invalid_zero, out_v_q && out_user_q, out_data_q[47:16] == 32'd0, "invalid pressure is not zero")
	`PTC_ASSERT_NEXT(a_blocked_fills_skid, push && out_v_q && !m_tready, skid_v_q, "blocked result not kept in skid")

endmodule

### sim/ptc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensation result checker
// Watches the calibration, input and output channels of the compensation
// block, computes the expected temperature and pressure for every accepted
// input beat and compares each output beat with the oldest pending value.
// ----------------------------------------------------------------------------
module ptc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [15:0] temp_centi;
		logic [31:0] press_q24_8;
		logic        press_invalid;
	} comp_result_t;

	logic [47:0] cal_temp;
	logic [63:0] cal_pa;
	logic [63:0] cal_pb;
	logic [15:0] cal_pc;
	comp_result_t expected_results[$];

	assign pending_count = expected_results.size();

	// Compensates one reading pair with the current calibration.
	function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
		comp_result_t r;
		logic signed [31:0] t1, t2, t3, dt, dsq, a, b, fine, t;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, p, ph, w1, w2, num, mn, md, q;
		t1 = {16'd0, cal_temp[15:0]};
		t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
		t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
		a = (({12'd0, raw_t} >>> 3) - (t1 <<< 1)) * t2;
		a = a >>> 11;
		dt = ({12'd0, raw_t} >>> 4) - t1;
		dsq = dt * dt;
		dsq = dsq >>> 12;
		b = dsq * t3;
		b = b >>> 14;
		fine = a + b;
		t = fine * 5 + 128;
		t = t >>> 8;
		if (t < -32768) r.temp_centi = 16'h8000;
		else if (t > 32767) r.temp_centi = 16'h7FFF;
		else r.temp_centi = t[15:0];

		p1 = {48'd0, cal_pa[15:0]};
		p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
		p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
		p4 = {{48{cal_pa[63]}}, cal_pa[63:48]};
		p5 = {{48{cal_pb[15]}}, cal_pb[15:0]};
		p6 = {{48{cal_pb[31]}}, cal_pb[31:16]};
		p7 = {{48{cal_pb[47]}}, cal_pb[47:32]};
		p8 = {{48{cal_pb[63]}}, cal_pb[63:48]};
		p9 = {{48{cal_pc[15]}}, cal_pc};
		v1 = 64'(fine) - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		r.press_q24_8 = '0;
		r.press_invalid = 1'b0;
		if (v1 == 0) begin
			r.press_invalid = 1'b1;
		end else begin
			p = 64'sd1048576 - {44'd0, raw_p};
			num = ((p <<< 31) - v2) * 64'sd3125;
			// Truncating division on magnitudes; the most negative value wraps.
			mn = num[63] ? -num : num;
			md = v1[63] ? -v1 : v1;
			q = $signed(64'($unsigned(mn) / $unsigned(md)));
			p = (num[63] != v1[63]) ? -q : q;
			ph = p >>> 13;
			w1 = (p9 * ph * ph) >>> 25;
			w2 = (p8 * p) >>> 19;
			p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
			if (p[63]) r.press_q24_8 = '0;
			else if (p > 64'sd4294967295) r.press_q24_8 = 32'hFFFFFFFF;
			else r.press_q24_8 = p[31:0];
		end
		return r;
	endfunction

	// Tracks calibration writes, queues predictions and checks output beats.
	always @(posedge clk or negedge arst_n) begin
		comp_result_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			cal_temp <= '0;
			cal_pa <= '0;
			cal_pb <= '0;
			cal_pc <= '0;
			fail_count <= 0;
			expected_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected output beat %h", m_tdata);
					errs = errs + 1;
				end else begin
					e = expected_results.pop_front();
					if (m_tdata[15:0] !== e.temp_centi) begin
						$error("temp_centi expected %0d actual %0d",
							$signed(e.temp_centi), $signed(m_tdata[15:0]));
						errs = errs + 1;
					end
					if (m_tdata[47:16] !== e.press_q24_8) begin
						$error("press_q24_8 expected %0d actual %0d",
							e.press_q24_8, m_tdata[47:16]);
						errs = errs + 1;
					end
					if (m_tuser !== e.press_invalid) begin
						$error("press_invalid expected %0d actual %0d",
							e.press_invalid, m_tuser);
						errs = errs + 1;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ptc_pkg::REG_TEMP_CALIB: cal_temp <= cfg_data[47:0];
					ptc_pkg::REG_PRESS_A: cal_pa <= cfg_data;
					ptc_pkg::REG_PRESS_B: cal_pb <= cfg_data;
					ptc_pkg::REG_PRESS_C: cal_pc <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### sim/pressure_temp_compensation_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Compensation block testbench
// Loads several calibration sets, from typical sensor values to all-zero and
// all-one extremes, and streams directed and random reading pairs with random
// gaps on both sides while the checker compares every result.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_top_tb;

	localparam int LATENCY = 100;
	localparam int CYCLE_LIMIT = 1500000;

	// Register indexes outside the map; writes to them are ignored.
	localparam logic [7:0] REG_UNUSED = 8'd4;
	localparam logic [7:0] REG_TOP    = 8'hFF;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          pending_count;
	int          cycle_count = 0;
	int          rx_wait;
	bit          fast_phase;

	pressure_temp_compensation_top u_top (.*);

	ptc_checker u_checker (.*);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver that waits a random number of cycles after each beat, none in
	// the fast phases.
	always @(posedge clk or negedge arst_n) begin
		int rwait;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			rwait = fast_phase ? 0 : int'($urandom_range(0, 17));
			m_tready <= (rwait == 0);
			rx_wait <= rwait;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Presents one register write; the caller drops cfg_valid afterwards.
	task automatic write_reg(logic [7:0] idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_calib(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
		logic [15:0] pc);
		write_reg(ptc_pkg::REG_TEMP_CALIB, {16'd0, tc});
		write_reg(ptc_pkg::REG_PRESS_A, pa);
		write_reg(ptc_pkg::REG_PRESS_B, pb);
		write_reg(ptc_pkg::REG_PRESS_C, {48'd0, pc});
		cfg_valid <= 1'b0;
	endtask

	// Sends one reading pair after a random gap.
	task automatic send_pair(logic [19:0] raw_t, logic [19:0] raw_p);
		int gap;
		gap = fast_phase ? 0 : int'($urandom_range(0, 17));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {raw_p, raw_t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// Random calibration near typical sensor values, with random bit noise.
	task automatic random_calib();
		logic [15:0] w[12];
		for (int i = 0; i < 12; i++) w[i] = 16'($urandom());
		if ($urandom_range(0, 3) != 0) begin
			w[0] = 16'(27504 + $urandom_range(0, 2000));
			w[1] = 16'(26435 + $urandom_range(0, 500));
			w[2] = 16'(-16'sd1000 + $urandom_range(0, 2000));
			w[3] = 16'(36477 + $urandom_range(0, 2000));
			w[4] = 16'(-16'sd10685 + $urandom_range(0, 500));
			w[5] = 16'(3024 + $urandom_range(0, 300));
			w[6] = 16'(2855 + $urandom_range(0, 300));
			w[7] = 16'(140 + $urandom_range(0, 100));
			w[8] = 16'(-16'sd7 + $urandom_range(0, 14));
			w[9] = 16'(15500 + $urandom_range(0, 400));
			w[10] = 16'(-16'sd14600 + $urandom_range(0, 400));
			w[11] = 16'(6000 + $urandom_range(0, 200));
		end
		load_calib({w[2], w[1], w[0]}, {w[6], w[5], w[4], w[3]},
			{w[10], w[9], w[8], w[7]}, w[11]);
	endtask

	// Random pair, mostly in the range a real sensor produces.
	task automatic random_pair();
		if ($urandom_range(0, 4) != 0)
			send_pair(20'(20'd480000 + $urandom_range(0, 120000)),
				20'(20'd380000 + $urandom_range(0, 250000)));
		else
			send_pair(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)));
	endtask

	initial begin
		arst_n = 1'b0;
		fast_phase = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: zero divisor on every beat.
		send_pair(20'd0, 20'd0);
		send_pair(20'hFFFFF, 20'hFFFFF);
		drain();

		// Typical calibration with field extremes and an ignored register.
		load_calib({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024,
			16'hD843, 16'd36477}, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_TOP, 64'h0);
		cfg_valid <= 1'b0;
		send_pair(20'd519888, 20'd415148);
		send_pair(20'd0, 20'd0);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'd0, 20'hFFFFF);
		send_pair(20'hFFFFF, 20'd0);
		send_pair(20'h55555, 20'hAAAAA);
		send_pair(20'hAAAAA, 20'h55555);
		drain();

		// All-ones calibration: saturations and wrapping.
		load_calib('1, '1, '1, '1);
		send_pair(20'd0, 20'd0);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'h80000, 20'h12345);
		drain();

		// Strong extremes to push temperature and pressure clamps both ways.
		load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, 16'h7FFF);
		send_pair(20'd0, 20'd0);
		send_pair(20'hFFFFF, 20'hFFFFF);
		send_pair(20'h7FFFF, 20'h00001);
		drain();
		load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
			{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 16'h8000);
		send_pair(20'd0, 20'hFFFFF);
		send_pair(20'hFFFFF, 20'd0);
		drain();

		// Random phases with fresh calibration each time.
		for (int ph = 0; ph < 16; ph++) begin
			fast_phase = (ph % 4 == 3);
			random_calib();
			for (int i = 0; i < 100; i++) random_pair();
			drain();
		end
		fast_phase = 1'b0;

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
